/* sv/enig_pkg.sv */
// ---------------------------------------------------------------------------
// Enigma cipher package
// Shared types, constants and letter arithmetic for the three-rotor cipher.
// ---------------------------------------------------------------------------
package enig_pkg;

  // Alphabet and plugboard sizing.
  localparam int LETTERS        = 26;
  localparam int NUM_ROTORS     = 5;
  localparam int MAX_PLUG_PAIRS = 13;
  localparam int PLUG_SPLIT     = (MAX_PLUG_PAIRS + 1) / 2;
  localparam int PLUG_BITS      = 10 * MAX_PLUG_PAIRS;
  localparam int QUEUE_DEPTH    = 4;

  // Item function codes.
  localparam logic FUNC_ENCIPHER = 1'b0;
  localparam logic FUNC_RESTART  = 1'b1;

  // Configuration register widths.
  localparam int W_WHEEL = 9;
  localparam int W_RING  = 15;
  localparam int W_START = 15;
  localparam int W_COUNT = 4;
  localparam int W_PAIRS = 50;
  localparam int W_PAIRC = 30;

  // Configuration reset values (rotors I, II, III; rings and A W E start).
  localparam logic [W_WHEEL-1:0] RST_WHEEL   = 9'd66;
  localparam logic [W_RING-1:0]  RST_RING    = 15'd20214;
  localparam logic [W_START-1:0] RST_START   = 15'd4800;
  localparam logic [W_COUNT-1:0] RST_COUNT   = 4'd2;
  localparam logic [W_PAIRS-1:0] RST_PAIRS_A = 50'd150912;

  // Register map, one entry per 8-byte slot.
  typedef enum logic [2:0] {
    REG_WHEEL_ORDER  = 3'd0,
    REG_RING         = 3'd1,
    REG_START        = 3'd2,
    REG_PLUG_COUNT   = 3'd3,
    REG_PAIRS_A      = 3'd4,
    REG_PAIRS_B      = 3'd5,
    REG_PAIRS_C      = 3'd6
  } cfg_reg_t;

  typedef logic [4:0] letter_t;
  typedef logic [2:0] wheel_t;

  // Rotor wirings I..V, reflector B and notch letters.
  localparam logic [8*LETTERS-1:0] WIRING [NUM_ROTORS] = '{
    "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
    "AJDKSIRUXBLHWTMCQGZNPYFVOE",
    "BDFHJLCPRTXVZNYEIWGAKMUSQO",
    "ESOVPZJAYQUIRHXLNFTGKDCMWB",
    "VZBRGITYUPSDNHLXAWMJQOFECK"
  };
  localparam logic [8*LETTERS-1:0] REFLECTOR = "YRUHQSLDPXNGOKMIEBFZCWVJAT";
  localparam letter_t NOTCH [NUM_ROTORS] = '{5'd16, 5'd4, 5'd21, 5'd9, 5'd25};

  // One queued item: the folded letter and the rotor positions it sees.
  typedef struct packed {
    letter_t           letter;
    logic [2:0][4:0]   pos;
  } enig_item_t;

  // Decoded configuration seen by the substitution path.
  typedef struct packed {
    logic [2:0][2:0]       wheel;
    logic [2:0][4:0]       ring;
    logic [W_COUNT-1:0]    plug_n;
    logic [PLUG_BITS-1:0]  pairs;
  } enig_cfg_t;

  // Reduce a 5-bit code of 26 or more by 26.
  function automatic letter_t fold5(input logic [4:0] x);
    return (x >= 5'(LETTERS)) ? 5'(x - 5'(LETTERS)) : x;
  endfunction

  function automatic letter_t add26(input letter_t a, input letter_t b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 6'(LETTERS)) ? 5'(s - 6'(LETTERS)) : 5'(s);
  endfunction

  function automatic letter_t sub26(input letter_t a, input letter_t b);
    logic [5:0] s;
    s = {1'b0, a} + 6'(LETTERS) - {1'b0, b};
    return (a >= b) ? 5'(a - b) : 5'(s);
  endfunction

  // Rotor choices above V are treated as V.
  function automatic wheel_t clamp_wheel(input logic [2:0] w);
    return (w > 3'(NUM_ROTORS - 1)) ? 3'(NUM_ROTORS - 1) : w;
  endfunction

  // Letter at position i of a wiring string.
  function automatic letter_t char_at(input logic [8*LETTERS-1:0] s, input letter_t i);
    int         sh;
    logic [7:0] ch;
    sh = 8 * (LETTERS - 1 - int'(i));
    ch = (i < 5'(LETTERS)) ? s[sh +: 8] : 8'd65;
    return 5'(ch - 8'd65);
  endfunction

  function automatic letter_t rotor_fwd(input wheel_t w, input letter_t c);
    return char_at(WIRING[clamp_wheel(w)], c);
  endfunction

  // Inverse wiring: position whose forward image is c, A if none.
  function automatic letter_t rotor_inv(input wheel_t w, input letter_t c);
    letter_t r;
    logic    found;
    r     = '0;
    found = 1'b0;
    for (int j = 0; j < LETTERS; j++) begin
      if (!found && rotor_fwd(w, 5'(j)) == c) begin
        r     = 5'(j);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic letter_t reflect(input letter_t c);
    return char_at(REFLECTOR, c);
  endfunction

  function automatic letter_t notch_of(input wheel_t w);
    return NOTCH[clamp_wheel(w)];
  endfunction

  // One rotor pass with its offset, forwards or through the inverse wiring.
  function automatic letter_t pass_fwd(input letter_t c, input wheel_t w,
                                       input letter_t off);
    return sub26(rotor_fwd(w, add26(c, off)), off);
  endfunction

  function automatic letter_t pass_inv(input letter_t c, input wheel_t w,
                                       input letter_t off);
    return sub26(rotor_inv(w, add26(c, off)), off);
  endfunction

  // Apply plugboard pairs lo..hi-1 in order, only those below the count.
  function automatic letter_t plug_steps(input letter_t c,
                                         input logic [PLUG_BITS-1:0] pairs,
                                         input logic [W_COUNT-1:0] n,
                                         input int lo, input int hi);
    letter_t r;
    letter_t a;
    letter_t b;
    r = c;
    for (int k = lo; k < hi; k++) begin
      a = fold5(pairs[10*k +: 5]);
      b = fold5(pairs[10*k+5 +: 5]);
      if (W_COUNT'(k) < n) begin
        if (r == a) begin
          r = b;
        end else if (r == b) begin
          r = a;
        end
      end
    end
    return r;
  endfunction

endpackage

/* sv/enig_front.sv */
// ---------------------------------------------------------------------------
// Enigma front end
// Accepts items, steps the rotors and queues each letter with its positions.
// ---------------------------------------------------------------------------
module enig_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_func,
  input  logic [4:0]                    in_letter_in,
  input  logic                          q_full,
  input  logic [2:0][2:0]               wheel,
  input  logic [enig_pkg::W_START-1:0]  start_pos,
  output logic                          push,
  output enig_pkg::enig_item_t          push_item
);

  logic [2:0][4:0] pos_r, pos_nxt, step_pos;
  logic            pend_r, pend_nxt, step_pend;
  logic            accept;

  assign accept = in_valid && !q_full;

  // Rotor stepping with the pending double step and the fast notch carry.
  always_comb begin
    step_pos    = pos_r;
    step_pend   = pend_r;
    step_pos[0] = enig_pkg::add26(pos_r[0], 5'd1);
    if (pend_r) begin
      step_pos[1] = enig_pkg::add26(pos_r[1], 5'd1);
      step_pos[2] = enig_pkg::add26(pos_r[2], 5'd1);
      step_pend   = 1'b0;
    end
    if (step_pos[0] == enig_pkg::notch_of(wheel[0])) begin
      step_pos[1] = enig_pkg::add26(step_pos[1], 5'd1);
      if (step_pos[1] == enig_pkg::notch_of(wheel[1])) begin
        step_pend = 1'b1;
      end
    end
  end

  // Next state: restart reloads the start positions, a letter steps.
  always_comb begin
    pos_nxt  = pos_r;
    pend_nxt = pend_r;
    if (accept) begin
      if (in_func == enig_pkg::FUNC_RESTART) begin
        for (int i = 0; i < 3; i++) begin
          pos_nxt[i] = enig_pkg::fold5(start_pos[5*i +: 5]);
        end
        pend_nxt = 1'b0;
      end else begin
        pos_nxt  = step_pos;
        pend_nxt = step_pend;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= enig_pkg::fold5(enig_pkg::RST_START[5*i +: 5]);
      end
      pend_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Letters go to the queue with the positions after stepping.
  assign push             = accept && (in_func == enig_pkg::FUNC_ENCIPHER);
  assign push_item.letter = enig_pkg::fold5(in_letter_in);
  assign push_item.pos    = step_pos;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r[0] < 5'd26 && pos_r[1] < 5'd26 && pos_r[2] < 5'd26)
    else $error("rotor position out of range");
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_func == enig_pkg::FUNC_RESTART |=> !pend_r && !$past(push))
    else $error("restart left the double step pending or queued an item");
`endif

endmodule

/* sv/enig_fifo.sv */
// ---------------------------------------------------------------------------
// Enigma item queue
// Short queue between the stepping front end and the substitution pipeline.
// ---------------------------------------------------------------------------
module enig_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  enig_pkg::enig_item_t push_item,
  input  logic                 pop,
  output logic                 full,
  output logic                 empty,
  output enig_pkg::enig_item_t head
);

  localparam int PW = $clog2(enig_pkg::QUEUE_DEPTH);

  enig_pkg::enig_item_t mem_r [enig_pkg::QUEUE_DEPTH];
  logic [PW-1:0]        wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PW:0]          cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(enig_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = do_push ? PW'(wr_r + 1'b1) : wr_r;
    rd_nxt  = do_pop  ? PW'(rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = (PW+1)'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = (PW+1)'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(enig_pkg::QUEUE_DEPTH) &&
    (cnt_r == '0 || cnt_r == (PW+1)'(enig_pkg::QUEUE_DEPTH) || wr_r != rd_r))
    else $error("queue count disagrees with pointers");
`endif

endmodule

/* sv/enig_back.sv */
// ---------------------------------------------------------------------------
// Enigma substitution pipeline
// Plugboard, rotors, reflector, inverse rotors and plugboard in ten stages.
// ---------------------------------------------------------------------------
module enig_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  enig_pkg::enig_cfg_t  cfg,
  input  logic                 q_empty,
  input  enig_pkg::enig_item_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [4:0]           out_letter_out
);

  localparam int NSTG = 10;

  typedef struct packed {
    logic [4:0]      c;
    logic [2:0][4:0] off;
  } stg_t;

  stg_t            stg_r [NSTG];
  stg_t            stg_nxt [NSTG];
  logic [NSTG-1:0] vld_r, vld_nxt;
  logic            adv;

  // The whole pipeline moves unless the output item is held.
  assign adv = !(vld_r[NSTG-1] && out_stall);
  assign pop = adv && !q_empty;

  // One operation per stage, except that the third rotor pass and the reflector share a stage.
  always_comb begin
    stg_nxt[0].c = enig_pkg::plug_steps(head.letter, cfg.pairs, cfg.plug_n,
                                        0, enig_pkg::PLUG_SPLIT);
    for (int k = 0; k < 3; k++) begin
      stg_nxt[0].off[k] = enig_pkg::sub26(head.pos[k], cfg.ring[k]);
    end
    for (int s = 1; s < NSTG; s++) begin
      stg_nxt[s] = stg_r[s-1];
    end
    stg_nxt[1].c = enig_pkg::plug_steps(stg_r[0].c, cfg.pairs, cfg.plug_n,
                                        enig_pkg::PLUG_SPLIT,
                                        enig_pkg::MAX_PLUG_PAIRS);
    stg_nxt[2].c = enig_pkg::pass_fwd(stg_r[1].c, cfg.wheel[0], stg_r[1].off[0]);
    stg_nxt[3].c = enig_pkg::pass_fwd(stg_r[2].c, cfg.wheel[1], stg_r[2].off[1]);
    stg_nxt[4].c = enig_pkg::reflect(
                     enig_pkg::pass_fwd(stg_r[3].c, cfg.wheel[2], stg_r[3].off[2]));
    stg_nxt[5].c = enig_pkg::pass_inv(stg_r[4].c, cfg.wheel[2], stg_r[4].off[2]);
    stg_nxt[6].c = enig_pkg::pass_inv(stg_r[5].c, cfg.wheel[1], stg_r[5].off[1]);
    stg_nxt[7].c = enig_pkg::pass_inv(stg_r[6].c, cfg.wheel[0], stg_r[6].off[0]);
    stg_nxt[8].c = enig_pkg::plug_steps(stg_r[7].c, cfg.pairs, cfg.plug_n,
                                        0, enig_pkg::PLUG_SPLIT);
    stg_nxt[9].c = enig_pkg::plug_steps(stg_r[8].c, cfg.pairs, cfg.plug_n,
                                        enig_pkg::PLUG_SPLIT,
                                        enig_pkg::MAX_PLUG_PAIRS);
  end

  assign vld_nxt = {vld_r[NSTG-2:0], pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // Stage payload needs no reset.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NSTG; s++) begin
        stg_r[s] <= stg_nxt[s];
      end
    end
  end

  assign out_valid      = vld_r[NSTG-1];
  assign out_letter_out = stg_r[NSTG-1].c;

`ifndef SYNTHESIS
  a_out_letter: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_letter_out < 5'd26)
    else $error("result letter out of range");
`endif

endmodule

/* sv/three_rotor_enigma_cipher.sv */
// ---------------------------------------------------------------------------
// Three-rotor Enigma cipher
// Throughput: one item per cycle while out_stall is low, set by the ten-stage substitution pipeline
// behind a four-entry queue; a restart item gives no result.
// Reset: configuration returns to its defaults, positions to A W E, flag clear.
// ---------------------------------------------------------------------------
module three_rotor_enigma_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [4:0]  in_letter_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_letter_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [enig_pkg::W_WHEEL-1:0] wheel_r;
  logic [enig_pkg::W_RING-1:0]  ring_r;
  logic [enig_pkg::W_START-1:0] start_r;
  logic [enig_pkg::W_COUNT-1:0] count_r;
  logic [enig_pkg::W_PAIRS-1:0] pairs_a_r, pairs_b_r;
  logic [enig_pkg::W_PAIRC-1:0] pairs_c_r;
  enig_pkg::cfg_reg_t           reg_sel;
  logic                         wr_en;

  enig_pkg::enig_cfg_t  cfg;
  enig_pkg::enig_item_t push_item, head;
  logic                 push, pop, q_full, q_empty;

  // Register port: always ready, eight bytes per register.
  assign pready  = 1'b1;
  assign reg_sel = enig_pkg::cfg_reg_t'(paddr[5:3]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_r   <= enig_pkg::RST_WHEEL;
      ring_r    <= enig_pkg::RST_RING;
      start_r   <= enig_pkg::RST_START;
      count_r   <= enig_pkg::RST_COUNT;
      pairs_a_r <= enig_pkg::RST_PAIRS_A;
      pairs_b_r <= '0;
      pairs_c_r <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        enig_pkg::REG_WHEEL_ORDER: wheel_r   <= pwdata[enig_pkg::W_WHEEL-1:0];
        enig_pkg::REG_RING:        ring_r    <= pwdata[enig_pkg::W_RING-1:0];
        enig_pkg::REG_START:       start_r   <= pwdata[enig_pkg::W_START-1:0];
        enig_pkg::REG_PLUG_COUNT:  count_r   <= pwdata[enig_pkg::W_COUNT-1:0];
        enig_pkg::REG_PAIRS_A:     pairs_a_r <= pwdata[enig_pkg::W_PAIRS-1:0];
        enig_pkg::REG_PAIRS_B:     pairs_b_r <= pwdata[enig_pkg::W_PAIRS-1:0];
        enig_pkg::REG_PAIRS_C:     pairs_c_r <= pwdata[enig_pkg::W_PAIRC-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_sel)
      enig_pkg::REG_WHEEL_ORDER: prdata = 64'(wheel_r);
      enig_pkg::REG_RING:        prdata = 64'(ring_r);
      enig_pkg::REG_START:       prdata = 64'(start_r);
      enig_pkg::REG_PLUG_COUNT:  prdata = 64'(count_r);
      enig_pkg::REG_PAIRS_A:     prdata = 64'(pairs_a_r);
      enig_pkg::REG_PAIRS_B:     prdata = 64'(pairs_b_r);
      enig_pkg::REG_PAIRS_C:     prdata = 64'(pairs_c_r);
      default:                   prdata = '0;
    endcase
  end

  // Decoded configuration: clamped rotor choices, folded rings, saturated count.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cfg.wheel[i] = enig_pkg::clamp_wheel(wheel_r[3*i +: 3]);
      cfg.ring[i]  = enig_pkg::fold5(ring_r[5*i +: 5]);
    end
    cfg.plug_n = (count_r > enig_pkg::W_COUNT'(enig_pkg::MAX_PLUG_PAIRS))
               ? enig_pkg::W_COUNT'(enig_pkg::MAX_PLUG_PAIRS) : count_r;
    cfg.pairs  = {pairs_c_r, pairs_b_r, pairs_a_r};
  end

  assign in_stall = q_full;

  enig_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_func      (in_func),
    .in_letter_in (in_letter_in),
    .q_full       (q_full),
    .wheel        (cfg.wheel),
    .start_pos    (start_r),
    .push         (push),
    .push_item    (push_item)
  );

  enig_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  enig_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_letter_out (out_letter_out)
  );

endmodule
